[sv/hsvrgb_pkg.sv]
// Shared constants, types and helpers for the HSV to RGB pixel converter.
package hsvrgb_pkg;

    localparam int HUE_W     = 10;
    localparam int PCT_W     = 7;
    localparam int LEVEL_W   = 8;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;
    localparam int NSTAGE    = 7;

    localparam int HUE_CIRCLE   = 360;
    localparam int SECTOR_SPAN  = 60;
    localparam int PERCENT_FULL = 100;

    // floor(x / 100) = (x * 5243) >> 19 exactly for x < 43690
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    // floor(x / 60) = (x * 17477) >> 20 exactly for x < 23831
    localparam int DIV60_MUL    = 17477;
    localparam int DIV60_SHIFT  = 20;

    localparam int WIDE_W = 15;   // products up to 255 * 100
    localparam int FRAC_W = 6;

    typedef logic [HUE_W-1:0]   hue_t;
    typedef logic [PCT_W-1:0]   pct_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [WIDE_W-1:0]  wide_t;
    typedef logic [FRAC_W-1:0]  frac_t;

    typedef enum logic [2:0] {
        SEC_RED_UP_GREEN = 3'd0,
        SEC_GREEN_DN_RED = 3'd1,
        SEC_GREEN_UP_BLU = 3'd2,
        SEC_BLUE_DN_GRN  = 3'd3,
        SEC_BLUE_UP_RED  = 3'd4,
        SEC_RED_DN_BLUE  = 3'd5
    } sector_t;

    function automatic pct_t clamp_pct(input pct_t p);
        clamp_pct = (p > pct_t'(PERCENT_FULL)) ? pct_t'(PERCENT_FULL) : p;
    endfunction

endpackage

[sv/hsvrgb_datapath.sv]
// Seven-stage arithmetic datapath of the HSV to RGB converter.
module hsvrgb_datapath (
    input  logic                aclk,
    input  logic                en,
    input  hsvrgb_pkg::hue_t    hue,
    input  hsvrgb_pkg::pct_t    saturation,
    input  hsvrgb_pkg::pct_t    brightness,
    output hsvrgb_pkg::level_t  red,
    output hsvrgb_pkg::level_t  green,
    output hsvrgb_pkg::level_t  blue
);
    import hsvrgb_pkg::*;

    localparam int VM_PROD_W = WIDE_W + 13;
    localparam int RP_PROD_W = WIDE_W + 15;

    // stage 1: wrap hue, clamp percents, v*255
    hue_t    h1_reg, h1_next;
    pct_t    s1_reg;
    wide_t   vb1_reg;
    // stage 2: vmax, sector, fraction
    level_t  vmax2_reg, vmax2_next;
    pct_t    s2_reg;
    sector_t sec2_reg, sec2_next;
    frac_t   fr2_reg, fr2_next;
    // stage 3: vmax * (100 - s)
    level_t  vmax3_reg;
    wide_t   pr3_reg;
    sector_t sec3_reg;
    frac_t   fr3_reg;
    // stage 4: vmin
    level_t  vmax4_reg, vmin4_reg, vmin4_next;
    sector_t sec4_reg;
    frac_t   fr4_reg;
    // stage 5: (vmax - vmin) * frac
    level_t  vmax5_reg, vmin5_reg;
    wide_t   rp5_reg;
    sector_t sec5_reg;
    // stage 6: ramp
    level_t  vmax6_reg, vmin6_reg, ramp6_reg, ramp6_next;
    sector_t sec6_reg;
    // stage 7: channel select
    level_t  r7_reg, g7_reg, b7_reg, r7_next, g7_next, b7_next;

    logic [VM_PROD_W-1:0] vm_prod, vn_prod;
    logic [RP_PROD_W-1:0] rp_prod;
    level_t               up, dn;
    pct_t                 v1;

    always_comb begin
        if (hue >= hue_t'(2 * HUE_CIRCLE)) begin
            h1_next = hue - hue_t'(2 * HUE_CIRCLE);
        end else if (hue >= hue_t'(HUE_CIRCLE)) begin
            h1_next = hue - hue_t'(HUE_CIRCLE);
        end else begin
            h1_next = hue;
        end
        v1 = clamp_pct(brightness);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_reg  <= h1_next;
            s1_reg  <= clamp_pct(saturation);
            vb1_reg <= (wide_t'(v1) << LEVEL_W) - wide_t'(v1);
        end
    end

    always_comb begin
        vm_prod   = VM_PROD_W'(vb1_reg) * VM_PROD_W'(DIV100_MUL);
        vmax2_next = vm_prod[DIV100_SHIFT +: LEVEL_W];
        if (h1_reg >= hue_t'(5 * SECTOR_SPAN)) begin
            sec2_next = SEC_RED_DN_BLUE;
            fr2_next  = frac_t'(h1_reg - hue_t'(5 * SECTOR_SPAN));
        end else if (h1_reg >= hue_t'(4 * SECTOR_SPAN)) begin
            sec2_next = SEC_BLUE_UP_RED;
            fr2_next  = frac_t'(h1_reg - hue_t'(4 * SECTOR_SPAN));
        end else if (h1_reg >= hue_t'(3 * SECTOR_SPAN)) begin
            sec2_next = SEC_BLUE_DN_GRN;
            fr2_next  = frac_t'(h1_reg - hue_t'(3 * SECTOR_SPAN));
        end else if (h1_reg >= hue_t'(2 * SECTOR_SPAN)) begin
            sec2_next = SEC_GREEN_UP_BLU;
            fr2_next  = frac_t'(h1_reg - hue_t'(2 * SECTOR_SPAN));
        end else if (h1_reg >= hue_t'(SECTOR_SPAN)) begin
            sec2_next = SEC_GREEN_DN_RED;
            fr2_next  = frac_t'(h1_reg - hue_t'(SECTOR_SPAN));
        end else begin
            sec2_next = SEC_RED_UP_GREEN;
            fr2_next  = frac_t'(h1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vmax2_reg <= vmax2_next;
            s2_reg    <= s1_reg;
            sec2_reg  <= sec2_next;
            fr2_reg   <= fr2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vmax3_reg <= vmax2_reg;
            pr3_reg   <= wide_t'(vmax2_reg) * wide_t'(pct_t'(PERCENT_FULL) - s2_reg);
            sec3_reg  <= sec2_reg;
            fr3_reg   <= fr2_reg;
        end
    end

    always_comb begin
        vn_prod    = VM_PROD_W'(pr3_reg) * VM_PROD_W'(DIV100_MUL);
        vmin4_next = vn_prod[DIV100_SHIFT +: LEVEL_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vmax4_reg <= vmax3_reg;
            vmin4_reg <= vmin4_next;
            sec4_reg  <= sec3_reg;
            fr4_reg   <= fr3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vmax5_reg <= vmax4_reg;
            vmin5_reg <= vmin4_reg;
            rp5_reg   <= wide_t'(vmax4_reg - vmin4_reg) * wide_t'(fr4_reg);
            sec5_reg  <= sec4_reg;
        end
    end

    always_comb begin
        rp_prod    = RP_PROD_W'(rp5_reg) * RP_PROD_W'(DIV60_MUL);
        ramp6_next = rp_prod[DIV60_SHIFT +: LEVEL_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vmax6_reg <= vmax5_reg;
            vmin6_reg <= vmin5_reg;
            ramp6_reg <= ramp6_next;
            sec6_reg  <= sec5_reg;
        end
    end

    always_comb begin
        up = vmin6_reg + ramp6_reg;
        dn = vmax6_reg - ramp6_reg;
        case (sec6_reg)
            SEC_RED_UP_GREEN: begin
                r7_next = vmax6_reg; g7_next = up;        b7_next = vmin6_reg;
            end
            SEC_GREEN_DN_RED: begin
                r7_next = dn;        g7_next = vmax6_reg; b7_next = vmin6_reg;
            end
            SEC_GREEN_UP_BLU: begin
                r7_next = vmin6_reg; g7_next = vmax6_reg; b7_next = up;
            end
            SEC_BLUE_DN_GRN: begin
                r7_next = vmin6_reg; g7_next = dn;        b7_next = vmax6_reg;
            end
            SEC_BLUE_UP_RED: begin
                r7_next = up;        g7_next = vmin6_reg; b7_next = vmax6_reg;
            end
            default: begin
                r7_next = vmax6_reg; g7_next = vmin6_reg; b7_next = dn;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r7_reg <= r7_next;
            g7_reg <= g7_next;
            b7_reg <= b7_next;
        end
    end

    assign red   = r7_reg;
    assign green = g7_reg;
    assign blue  = b7_reg;

endmodule

[sv/hsv_to_rgb_converter.sv]
// HSV to RGB converter: seven registered stages from input accept to m_tvalid.
// Throughput one word per cycle; the whole pipeline holds while an output word waits with m_tready low.
// A stall holds every stage, bubbles included, so no word is dropped or repeated.
// aresetn (synchronous, active low) clears all stage valid bits; data is not reset.
// Seven stages, each at most one constant or small multiply, add or compare chain.
module hsv_to_rgb_converter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hsvrgb_pkg::S_DATA_W-1:0]  s_tdata,  // hue[9:0], saturation[16:10], brightness[23:17]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hsvrgb_pkg::M_DATA_W-1:0]  m_tdata   // red[7:0], green[15:8], blue[23:16]
);
    import hsvrgb_pkg::*;

    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic              advance;
    level_t            red, green, blue;

    // The datapath shares one enable: advance every stage together whenever the
    // last stage is empty or its word is taken this cycle, and hold them all
    // otherwise so the waiting output word stays put.
    assign advance  = !valid_reg[NSTAGE-1] || m_tready;
    assign s_tready = advance;

    always_comb begin
        valid_next[0] = s_tvalid;
        for (int i = 1; i < NSTAGE; i++) begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    hsvrgb_datapath u_datapath (
        .aclk       (aclk),
        .en         (advance),
        .hue        (s_tdata[HUE_W-1:0]),
        .saturation (s_tdata[HUE_W +: PCT_W]),
        .brightness (s_tdata[HUE_W+PCT_W +: PCT_W]),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = {blue, green, red};

endmodule
